[rtl/esc_pkg.sv]
// ---------------------------------------------------------------------------
// esc_pkg: shared constants for the epoch seconds to calendar converter
// Field widths, reciprocal constants for the divisions by constants, and the
// March-based month table used to split a day of year into month and day.
// ---------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  // Pipeline depth: input register through result register
  localparam int unsigned PIPE_DEPTH = 7;

  // Field widths
  localparam int unsigned SECS_W  = 32;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 12;

  // Internal widths
  localparam int unsigned DAYS_W  = 16;  // whole days, up to 49710
  localparam int unsigned TOD_W   = 17;  // seconds of day, below 86400
  localparam int unsigned HRS_W   = 12;  // seconds of hour, below 3600
  localparam int unsigned CYC_W   = 6;   // four-year cycles, up to 34
  localparam int unsigned DOY4_W  = 11;  // day within a four-year cycle
  localparam int unsigned DOY_W   = 9;   // March-based day of year
  localparam int unsigned MP_W    = 4;   // March-based month index

  // Seconds / 86400 = (secs >> 7) / 675, by reciprocal
  localparam int unsigned DAY_PRE_SHIFT = 7;
  localparam int unsigned DAY_RCP_W     = 26;
  localparam logic [DAY_RCP_W-1:0] DAY_RCP = 26'd50903317;
  localparam int unsigned DAY_RCP_SHIFT = 35;
  localparam int unsigned DAY_PROD_W    = SECS_W - DAY_PRE_SHIFT + DAY_RCP_W;
  localparam logic [SECS_W-1:0] SECS_PER_DAY = 32'd86400;

  // Seconds of day / 3600 = (tod >> 4) / 225
  localparam int unsigned HOUR_PRE_SHIFT = 4;
  localparam int unsigned HOUR_RCP_W     = 14;
  localparam logic [HOUR_RCP_W-1:0] HOUR_RCP = 14'd9321;
  localparam int unsigned HOUR_RCP_SHIFT = 21;
  localparam int unsigned HOUR_PROD_W    = TOD_W - HOUR_PRE_SHIFT + HOUR_RCP_W;
  localparam logic [TOD_W-1:0] SECS_PER_HOUR = 17'd3600;

  // Seconds of hour / 60 = (x >> 2) / 15
  localparam int unsigned MIN_PRE_SHIFT = 2;
  localparam int unsigned MIN_RCP_W     = 11;
  localparam logic [MIN_RCP_W-1:0] MIN_RCP = 11'd1093;
  localparam int unsigned MIN_RCP_SHIFT = 14;
  localparam int unsigned MIN_PROD_W    = HRS_W - MIN_PRE_SHIFT + MIN_RCP_W;
  localparam logic [HRS_W-1:0] SECS_PER_MIN = 12'd60;

  // Day count rebased to 1968-03-01, with a skip over the missing 2100-02-29
  localparam logic [DAYS_W-1:0] EPOCH_OFFSET = 16'd671;
  localparam logic [DAYS_W-1:0] SKIP_2100    = 16'd47541;

  // Day count / 1461 by reciprocal
  localparam int unsigned CYC_RCP_W     = 17;
  localparam logic [CYC_RCP_W-1:0] CYC_RCP = 17'd91868;
  localparam int unsigned CYC_RCP_SHIFT = 27;
  localparam int unsigned CYC_PROD_W    = DAYS_W + CYC_RCP_W;
  localparam logic [DAYS_W-1:0] DAYS_PER_CYCLE = 16'd1461;

  // Year boundaries inside a four-year cycle
  localparam logic [DOY4_W-1:0] YEAR1_START = 11'd365;
  localparam logic [DOY4_W-1:0] YEAR2_START = 11'd730;
  localparam logic [DOY4_W-1:0] YEAR3_START = 11'd1095;

  localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1968;
  localparam int unsigned MONTHS = 12;
  localparam logic [MP_W-1:0] JAN_INDEX = 4'd10;

  // First day of each month, counted from March 1
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // March-based month that holds the given day of year
  function automatic logic [MP_W-1:0] month_of_doy(input logic [DOY_W-1:0] doy);
    logic [MP_W-1:0] mp;
    mp = '0;
    for (int i = 1; i < MONTHS; i++) begin
      if (doy >= month_start(MP_W'(i))) mp = MP_W'(i);
    end
    return mp;
  endfunction

endpackage

`default_nettype wire

[rtl/epoch_seconds_to_calendar.sv]
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar: Unix seconds to Gregorian date and time
// Seven-stage pipeline: day split by reciprocal multiply, time of day by two
// more reciprocal steps, date by four-year cycles and a March-based month.
// ---------------------------------------------------------------------------
// A beat moves from input stage A through B to F; its result is valid in G.
// Throughput: one beat per cycle unless the output stalls; each stage holds one
//   beat and moves it on when the next stage is empty or moving, so a stalled
//   output only fills the pipeline up behind it.
// Reset: rst_n clears the stage valid bits only; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SECS_W-1:0]   in_epoch_seconds,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SEC_W-1:0]         out_second_of_minute,
  output logic [MIN_W-1:0]         out_minute_of_hour,
  output logic [HOUR_W-1:0]        out_hour_of_day,
  output logic [DAY_W-1:0]         out_day_of_month,
  output logic [MONTH_W-1:0]       out_month_of_year,
  output logic [YEAR_W-1:0]        out_full_year
);

  localparam int unsigned LAST = PIPE_DEPTH - 1;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] ld;

  // Stage load enables: a stage loads when empty or when it drains downstream
  always_comb begin
    ld[LAST] = !vld_r[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld_r[LAST];

  // Advance stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (ld[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage A: input register
  logic [SECS_W-1:0] sa_secs_r;

  always_ff @(posedge clk) begin
    if (ld[0]) sa_secs_r <= in_epoch_seconds;
  end

  // Stage B: reciprocal product for the day count
  logic [SECS_W-1:0]     sb_secs_r;
  logic [DAY_PROD_W-1:0] sb_prod_r, sb_prod_nxt;

  assign sb_prod_nxt = DAY_PROD_W'(sa_secs_r[SECS_W-1:DAY_PRE_SHIFT])
                     * DAY_PROD_W'(DAY_RCP);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      sb_secs_r <= sa_secs_r;
      sb_prod_r <= sb_prod_nxt;
    end
  end

  // Stage C: whole days and seconds of day
  logic [DAYS_W-1:0] sc_days_r, sc_days_nxt;
  logic [TOD_W-1:0]  sc_tod_r, sc_tod_nxt;
  logic [SECS_W-1:0] sc_day_secs;

  assign sc_days_nxt = sb_prod_r[DAY_RCP_SHIFT +: DAYS_W];
  assign sc_day_secs = SECS_W'(sc_days_nxt) * SECS_PER_DAY;
  assign sc_tod_nxt  = TOD_W'(sb_secs_r - sc_day_secs);

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      sc_days_r <= sc_days_nxt;
      sc_tod_r  <= sc_tod_nxt;
    end
  end

  // Stage D: hour, rebased day count, four-year cycle
  logic [HOUR_W-1:0]      sd_hour_r, sd_hour_nxt;
  logic [TOD_W-1:0]       sd_tod_r;
  logic [DAYS_W-1:0]      sd_z_r, sd_z_nxt;
  logic [CYC_W-1:0]       sd_cyc_r, sd_cyc_nxt;
  logic [HOUR_PROD_W-1:0] sd_hour_prod;
  logic [CYC_PROD_W-1:0]  sd_cyc_prod;

  assign sd_hour_prod = HOUR_PROD_W'(sc_tod_r[TOD_W-1:HOUR_PRE_SHIFT])
                      * HOUR_PROD_W'(HOUR_RCP);
  assign sd_hour_nxt  = sd_hour_prod[HOUR_RCP_SHIFT +: HOUR_W];
  // skip the day that the four-year rule would insert at 2100-02-29
  assign sd_z_nxt     = sc_days_r + EPOCH_OFFSET
                      + DAYS_W'(sc_days_r >= SKIP_2100);
  assign sd_cyc_prod  = CYC_PROD_W'(sd_z_nxt) * CYC_PROD_W'(CYC_RCP);
  assign sd_cyc_nxt   = sd_cyc_prod[CYC_RCP_SHIFT +: CYC_W];

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      sd_hour_r <= sd_hour_nxt;
      sd_tod_r  <= sc_tod_r;
      sd_z_r    <= sd_z_nxt;
      sd_cyc_r  <= sd_cyc_nxt;
    end
  end

  // Stage E: seconds of hour, day within the cycle
  logic [HRS_W-1:0]  se_hs_r, se_hs_nxt;
  logic [HOUR_W-1:0] se_hour_r;
  logic [CYC_W-1:0]  se_cyc_r;
  logic [DOY4_W-1:0] se_doy4_r, se_doy4_nxt;
  logic [TOD_W-1:0]  se_hour_secs;
  logic [DAYS_W-1:0] se_cyc_days;

  assign se_hour_secs = TOD_W'(sd_hour_r) * SECS_PER_HOUR;
  assign se_hs_nxt    = HRS_W'(sd_tod_r - se_hour_secs);
  assign se_cyc_days  = DAYS_W'(sd_cyc_r) * DAYS_PER_CYCLE;
  assign se_doy4_nxt  = DOY4_W'(sd_z_r - se_cyc_days);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      se_hs_r   <= se_hs_nxt;
      se_hour_r <= sd_hour_r;
      se_cyc_r  <= sd_cyc_r;
      se_doy4_r <= se_doy4_nxt;
    end
  end

  // Stage F: minute, year within the cycle, March-based day of year
  logic [MIN_W-1:0]      sf_min_r, sf_min_nxt;
  logic [HRS_W-1:0]      sf_hs_r;
  logic [HOUR_W-1:0]     sf_hour_r;
  logic [CYC_W-1:0]      sf_cyc_r;
  logic [1:0]            sf_yoc_r, sf_yoc_nxt;
  logic [DOY_W-1:0]      sf_doy_r, sf_doy_nxt;
  logic [MIN_PROD_W-1:0] sf_min_prod;
  logic [DOY4_W-1:0]     sf_year_base;

  assign sf_min_prod = MIN_PROD_W'(se_hs_r[HRS_W-1:MIN_PRE_SHIFT])
                     * MIN_PROD_W'(MIN_RCP);
  assign sf_min_nxt  = sf_min_prod[MIN_RCP_SHIFT +: MIN_W];

  // Pick the year in the cycle; the last year holds the leap day
  always_comb begin
    if (se_doy4_r >= YEAR3_START) begin
      sf_yoc_nxt   = 2'd3;
      sf_year_base = YEAR3_START;
    end else if (se_doy4_r >= YEAR2_START) begin
      sf_yoc_nxt   = 2'd2;
      sf_year_base = YEAR2_START;
    end else if (se_doy4_r >= YEAR1_START) begin
      sf_yoc_nxt   = 2'd1;
      sf_year_base = YEAR1_START;
    end else begin
      sf_yoc_nxt   = 2'd0;
      sf_year_base = '0;
    end
  end

  assign sf_doy_nxt = DOY_W'(se_doy4_r - sf_year_base);

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      sf_min_r  <= sf_min_nxt;
      sf_hs_r   <= se_hs_r;
      sf_hour_r <= se_hour_r;
      sf_cyc_r  <= se_cyc_r;
      sf_yoc_r  <= sf_yoc_nxt;
      sf_doy_r  <= sf_doy_nxt;
    end
  end

  // Stage G: result register
  logic [MP_W-1:0]    sg_mp;
  logic [DOY_W-1:0]   sg_day0;
  logic [HRS_W-1:0]   sg_min_secs;
  logic [SEC_W-1:0]   sg_sec_nxt;
  logic [DAY_W-1:0]   sg_day_nxt;
  logic [MONTH_W-1:0] sg_month_nxt;
  logic [YEAR_W-1:0]  sg_year_nxt;

  assign sg_min_secs = HRS_W'(sf_min_r) * SECS_PER_MIN;
  assign sg_sec_nxt  = SEC_W'(sf_hs_r - sg_min_secs);
  assign sg_mp       = month_of_doy(sf_doy_r);
  assign sg_day0     = sf_doy_r - month_start(sg_mp);
  assign sg_day_nxt  = DAY_W'(sg_day0) + DAY_W'(1);

  // Map March-based month to calendar month; January and February roll over
  always_comb begin
    if (sg_mp >= JAN_INDEX) begin
      sg_month_nxt = MONTH_W'(sg_mp - JAN_INDEX) + MONTH_W'(1);
    end else begin
      sg_month_nxt = MONTH_W'(sg_mp) + MONTH_W'(3);
    end
  end

  assign sg_year_nxt = BASE_YEAR + YEAR_W'({sf_cyc_r, 2'b00})
                     + YEAR_W'(sf_yoc_r) + YEAR_W'(sg_mp >= JAN_INDEX);

  always_ff @(posedge clk) begin
    if (ld[LAST]) begin
      out_second_of_minute <= sg_sec_nxt;
      out_minute_of_hour   <= sf_min_r;
      out_hour_of_day      <= sf_hour_r;
      out_day_of_month     <= sg_day_nxt;
      out_month_of_year    <= sg_month_nxt;
      out_full_year        <= sg_year_nxt;
    end
  end

  // Result fields stay in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_second_of_minute < 6'd60) && (out_minute_of_hour < 6'd60)
                  && (out_hour_of_day < 5'd24))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_day_of_month != 5'd0) && (out_month_of_year != 4'd0)
                  && (out_month_of_year <= 4'd12))
    else $error("date out of range");

  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_month_of_year == 4'd2) |-> out_day_of_month <= 5'd29)
    else $error("February longer than 29 days");

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_full_year >= 12'd1970) && (out_full_year <= 12'd2106))
    else $error("year out of range");

  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted beat lost at the input stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
